@@ rtl/tksd_pkg.sv @@
// ----------------------------------------------------------------------------
// Terminal key sequence decoder package
// Shared types, byte constants and key lookup functions.
// ----------------------------------------------------------------------------
`default_nettype none

package tksd_pkg;

    localparam int unsigned SEQUENCE_MAX = 15;
    localparam int unsigned SEQ_LEN_W    = $clog2(SEQUENCE_MAX + 1);

    localparam int unsigned TICK_W  = 16;
    localparam int unsigned CODE_W  = 21;
    localparam int unsigned KEY_W   = 5;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [0:0] CFG_ESC_TIMEOUT = 1'b0;
    localparam logic [0:0] CFG_UTF_TIMEOUT = 1'b1;

    localparam logic [TICK_W-1:0] ESC_TIMEOUT_RESET = 16'd50;
    localparam logic [TICK_W-1:0] UTF_TIMEOUT_RESET = 16'd20;

    localparam logic [BYTE_W-1:0] BYTE_ESC       = 8'h1B;
    localparam logic [BYTE_W-1:0] BYTE_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_DEL       = 8'h7F;
    localparam logic [BYTE_W-1:0] BYTE_BS        = 8'h08;
    localparam logic [BYTE_W-1:0] BYTE_ETX       = 8'h03;
    localparam logic [BYTE_W-1:0] BYTE_CSI       = 8'h5B;
    localparam logic [BYTE_W-1:0] BYTE_SS3       = 8'h4F;
    localparam logic [BYTE_W-1:0] BYTE_TILDE     = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_FINAL_LO  = 8'h40;
    localparam logic [BYTE_W-1:0] BYTE_FINAL_HI  = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_DIGIT_LO  = 8'h30;
    localparam logic [BYTE_W-1:0] BYTE_DIGIT_HI  = 8'h39;
    localparam logic [BYTE_W-1:0] BYTE_SPACE     = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_ASCII_TOP = 8'h80;
    localparam logic [BYTE_W-1:0] CTRL_OFFSET    = 8'h60;
    localparam logic [BYTE_W-1:0] NUM_SAT        = 8'hFF;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ESC  = 2'd1,
        MODE_SEQ  = 2'd2,
        MODE_UTF  = 2'd3
    } t_mode;

    typedef enum logic [KEY_W-1:0] {
        KC_NONE      = 5'd0,
        KC_CHAR      = 5'd1,
        KC_ENTER     = 5'd2,
        KC_TAB       = 5'd3,
        KC_BKSP      = 5'd4,
        KC_INTR      = 5'd5,
        KC_ESC       = 5'd6,
        KC_UP        = 5'd7,
        KC_DN        = 5'd8,
        KC_RT        = 5'd9,
        KC_LT        = 5'd10,
        KC_HOM       = 5'd11,
        KC_END       = 5'd12,
        KC_SHIFT_TAB = 5'd13,
        KC_PGUP      = 5'd14,
        KC_PGDN      = 5'd15,
        KC_DEL       = 5'd16,
        KC_F1        = 5'd17,
        KC_F2        = 5'd18,
        KC_F3        = 5'd19,
        KC_F4        = 5'd20,
        KC_F5        = 5'd21,
        KC_F6        = 5'd22,
        KC_F7        = 5'd23,
        KC_F8        = 5'd24,
        KC_F9        = 5'd25,
        KC_F10       = 5'd26,
        KC_F11       = 5'd27,
        KC_F12       = 5'd28
    } t_key;

    typedef struct packed {
        logic [TICK_W-1:0] esc_timeout;
        logic [TICK_W-1:0] utf_timeout;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        t_key              key_code;
        logic [CODE_W-1:0] char_code;
        logic              ctrl_flag;
        logic              alt_flag;
    } t_result;

    function automatic t_key letter_key(input logic [BYTE_W-1:0] b);
        t_key k;
        case (b)
            8'h41:   k = KC_UP;
            8'h42:   k = KC_DN;
            8'h43:   k = KC_RT;
            8'h44:   k = KC_LT;
            8'h48:   k = KC_HOM;
            8'h46:   k = KC_END;
            8'h5A:   k = KC_SHIFT_TAB;
            8'h50:   k = KC_F1;
            8'h51:   k = KC_F2;
            8'h52:   k = KC_F3;
            8'h53:   k = KC_F4;
            default: k = KC_NONE;
        endcase
        return k;
    endfunction

    function automatic t_key number_key(input logic [BYTE_W-1:0] n);
        t_key k;
        case (n)
            8'd1, 8'd7: k = KC_HOM;
            8'd4, 8'd8: k = KC_END;
            8'd3:       k = KC_DEL;
            8'd5:       k = KC_PGUP;
            8'd6:       k = KC_PGDN;
            8'd15:      k = KC_F5;
            8'd17:      k = KC_F6;
            8'd18:      k = KC_F7;
            8'd19:      k = KC_F8;
            8'd20:      k = KC_F9;
            8'd21:      k = KC_F10;
            8'd23:      k = KC_F11;
            8'd24:      k = KC_F12;
            default:    k = KC_NONE;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ rtl/tksd_in_if.sv @@
// ----------------------------------------------------------------------------
// Terminal input channel
// Carries one received byte or one timer tick per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tksd_in_if;
    logic                        valid;
    logic                        ready;
    logic                        is_tick;
    logic [tksd_pkg::BYTE_W-1:0] data_byte;

    modport source (output valid, output is_tick, output data_byte, input ready);
    modport sink   (input valid, input is_tick, input data_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/tksd_out_if.sv @@
// ----------------------------------------------------------------------------
// Key event channel
// Carries one decoded key event per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tksd_out_if;
    logic                        valid;
    logic                        ready;
    logic [tksd_pkg::KEY_W-1:0]  key_code;
    logic [tksd_pkg::CODE_W-1:0] char_code;
    logic                        ctrl_flag;
    logic                        alt_flag;

    modport source (output valid, output key_code, output char_code,
                    output ctrl_flag, output alt_flag, input ready);
    modport sink   (input valid, input key_code, input char_code,
                    input ctrl_flag, input alt_flag, output ready);
endinterface

`default_nettype wire

@@ rtl/tksd_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Timeout configuration registers
// Holds the escape and UTF-8 inter-byte timeouts written through the port.
// ----------------------------------------------------------------------------
`default_nettype none

module tksd_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [0:0]                   i_cfg_idx,
    input  wire logic [tksd_pkg::TICK_W-1:0]  i_cfg_data,
    output tksd_pkg::t_cfg                    o_cfg
);

    tksd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.esc_timeout <= tksd_pkg::ESC_TIMEOUT_RESET;
            r_cfg.utf_timeout <= tksd_pkg::UTF_TIMEOUT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tksd_pkg::CFG_ESC_TIMEOUT: r_cfg.esc_timeout <= i_cfg_data;
                tksd_pkg::CFG_UTF_TIMEOUT: r_cfg.utf_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ rtl/tksd_core.sv @@
// ----------------------------------------------------------------------------
// Decoder core
// Parser state and the combinational next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tksd_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_step,
    input  wire logic                         i_is_tick,
    input  wire logic [tksd_pkg::BYTE_W-1:0]  i_data_byte,
    input  wire tksd_pkg::t_cfg               i_cfg,
    output tksd_pkg::t_result                 o_res
);

    localparam int unsigned SW = tksd_pkg::SEQ_LEN_W;
    localparam int unsigned TW = tksd_pkg::TICK_W;
    localparam int unsigned CW = tksd_pkg::CODE_W;
    localparam int unsigned BW = tksd_pkg::BYTE_W;

    tksd_pkg::t_mode r_mode, n_mode;
    logic [TW-1:0]   r_tc, n_tc;
    logic [SW-1:0]   r_len, n_len;
    logic [BW-1:0]   r_first, n_first;
    logic [BW-1:0]   r_num, n_num;
    logic            r_nds, n_nds;
    logic [CW-1:0]   r_acc, n_acc;
    logic [1:0]      r_cl, n_cl;

    logic [TW-1:0]   tc_inc;
    logic [TW-1:0]   limit;
    logic [SW-1:0]   len_inc;
    logic [11:0]     num_mul;
    logic [1:0]      cl_dec;
    logic [CW-1:0]   acc_shift;
    logic [BW-1:0]   b;

    tksd_pkg::t_result res;

    assign b         = i_data_byte;
    assign tc_inc    = (r_tc != {TW{1'b1}}) ? r_tc + TW'(1) : r_tc;
    assign limit     = (r_mode == tksd_pkg::MODE_UTF) ? i_cfg.utf_timeout : i_cfg.esc_timeout;
    assign len_inc   = r_len + SW'(1);
    assign num_mul   = {4'd0, r_num} * 12'd10 + {8'd0, b[3:0]};
    assign cl_dec    = r_cl - 2'd1;
    assign acc_shift = {r_acc[CW-7:0], b[5:0]};

    always_comb begin
        n_mode  = r_mode;
        n_tc    = r_tc;
        n_len   = r_len;
        n_first = r_first;
        n_num   = r_num;
        n_nds   = r_nds;
        n_acc   = r_acc;
        n_cl    = r_cl;
        res     = '0;
        res.key_code = tksd_pkg::KC_NONE;

        if (i_is_tick) begin
            if (r_mode != tksd_pkg::MODE_IDLE) begin
                n_tc = tc_inc;
                if (tc_inc >= limit) begin
                    res.valid = 1'b1;
                    if (r_mode == tksd_pkg::MODE_ESC) begin
                        res.key_code = tksd_pkg::KC_ESC;
                    end
                end
            end
        end else begin
            case (r_mode)
                tksd_pkg::MODE_ESC: begin
                    if (b == tksd_pkg::BYTE_CSI || b == tksd_pkg::BYTE_SS3) begin
                        n_mode  = tksd_pkg::MODE_SEQ;
                        n_tc    = '0;
                        n_len   = '0;
                        n_first = '0;
                        n_num   = '0;
                        n_nds   = 1'b0;
                    end else begin
                        res.valid     = 1'b1;
                        res.key_code  = tksd_pkg::KC_CHAR;
                        res.char_code = CW'(b);
                        res.alt_flag  = 1'b1;
                    end
                end
                tksd_pkg::MODE_SEQ: begin
                    n_len = len_inc;
                    n_tc  = '0;
                    if (len_inc == SW'(1)) begin
                        n_first = b;
                    end
                    if (b inside {[tksd_pkg::BYTE_FINAL_LO:tksd_pkg::BYTE_FINAL_HI]}) begin
                        res.valid = 1'b1;
                        if (len_inc == SW'(1)) begin
                            res.key_code = tksd_pkg::letter_key(b);
                        end else if (b == tksd_pkg::BYTE_TILDE && !r_nds) begin
                            res.key_code = tksd_pkg::number_key(r_num);
                        end
                    end else begin
                        if (b inside {[tksd_pkg::BYTE_DIGIT_LO:tksd_pkg::BYTE_DIGIT_HI]}) begin
                            n_num = (num_mul > 12'd255) ? tksd_pkg::NUM_SAT : num_mul[BW-1:0];
                        end else begin
                            n_nds = 1'b1;
                        end
                        if (len_inc >= SW'(tksd_pkg::SEQUENCE_MAX)) begin
                            res.valid = 1'b1;
                        end
                    end
                end
                tksd_pkg::MODE_UTF: begin
                    if (b[7:6] != 2'b10) begin
                        res.valid = 1'b1;
                    end else begin
                        n_acc = acc_shift;
                        n_cl  = cl_dec;
                        n_tc  = '0;
                        if (cl_dec == 2'd0) begin
                            res.valid     = 1'b1;
                            res.key_code  = tksd_pkg::KC_CHAR;
                            res.char_code = acc_shift;
                        end
                    end
                end
                default: begin
                    if (b == tksd_pkg::BYTE_ESC) begin
                        n_mode = tksd_pkg::MODE_ESC;
                        n_tc   = '0;
                    end else if (b == tksd_pkg::BYTE_CR || b == tksd_pkg::BYTE_LF) begin
                        res.valid    = 1'b1;
                        res.key_code = tksd_pkg::KC_ENTER;
                    end else if (b == tksd_pkg::BYTE_TAB) begin
                        res.valid    = 1'b1;
                        res.key_code = tksd_pkg::KC_TAB;
                    end else if (b == tksd_pkg::BYTE_DEL || b == tksd_pkg::BYTE_BS) begin
                        res.valid    = 1'b1;
                        res.key_code = tksd_pkg::KC_BKSP;
                    end else if (b == tksd_pkg::BYTE_ETX) begin
                        res.valid    = 1'b1;
                        res.key_code = tksd_pkg::KC_INTR;
                    end else if (b < tksd_pkg::BYTE_SPACE) begin
                        res.valid     = 1'b1;
                        res.key_code  = tksd_pkg::KC_CHAR;
                        res.char_code = CW'(b + tksd_pkg::CTRL_OFFSET);
                        res.ctrl_flag = 1'b1;
                    end else if (b < tksd_pkg::BYTE_ASCII_TOP) begin
                        res.valid     = 1'b1;
                        res.key_code  = tksd_pkg::KC_CHAR;
                        res.char_code = CW'(b);
                    end else if (b[7:5] == 3'b110) begin
                        n_acc  = CW'(b[4:0]);
                        n_cl   = 2'd1;
                        n_mode = tksd_pkg::MODE_UTF;
                        n_tc   = '0;
                    end else if (b[7:4] == 4'b1110) begin
                        n_acc  = CW'(b[3:0]);
                        n_cl   = 2'd2;
                        n_mode = tksd_pkg::MODE_UTF;
                        n_tc   = '0;
                    end else if (b[7:3] == 5'b11110) begin
                        n_acc  = CW'(b[2:0]);
                        n_cl   = 2'd3;
                        n_mode = tksd_pkg::MODE_UTF;
                        n_tc   = '0;
                    end else begin
                        res.valid = 1'b1;
                    end
                end
            endcase
        end

        if (res.valid) begin
            n_mode = tksd_pkg::MODE_IDLE;
            n_tc   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= tksd_pkg::MODE_IDLE;
            r_tc    <= '0;
            r_len   <= '0;
            r_first <= '0;
            r_num   <= '0;
            r_nds   <= 1'b0;
            r_acc   <= '0;
            r_cl    <= '0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_tc    <= n_tc;
            r_len   <= n_len;
            r_first <= n_first;
            r_num   <= n_num;
            r_nds   <= n_nds;
            r_acc   <= n_acc;
            r_cl    <= n_cl;
        end
    end

    assign o_res = res;

endmodule

`default_nettype wire

@@ rtl/terminal_key_sequence_decoder.sv @@
// ----------------------------------------------------------------------------
// Terminal key sequence decoder
// Turns terminal bytes and timer ticks into key events.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle while the output is not stalled,
// either a received byte or a timer tick, and gives at most one key event for
// it. A word passes an input register and is decoded combinationally against
// the parser state into a result register, from which its event is offered on
// the output. The parser state is updated once per word, which sets the rate
// of one word per cycle. While an event waits downstream the decoder holds,
// and the input takes one more word into its register and then stalls until
// the event is taken. Timeouts are counted in ticks since the last byte, and
// the two timeout registers should be written only while no key sequence is
// in progress.
`default_nettype none

module terminal_key_sequence_decoder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [0:0]                   i_cfg_idx,
    input  wire logic [tksd_pkg::TICK_W-1:0]  i_cfg_data,
    tksd_in_if.sink                           i_in_ch,
    tksd_out_if.source                        o_out_ch
);

    tksd_pkg::t_cfg    cfg;
    tksd_pkg::t_result res;

    logic                        r_in_valid;
    logic                        r_in_tick;
    logic [tksd_pkg::BYTE_W-1:0] r_in_byte;
    logic                        r_out_valid;
    tksd_pkg::t_result           r_out;
    logic                        step;

    assign step          = r_in_valid && (!r_out_valid || o_out_ch.ready);
    assign i_in_ch.ready = !r_in_valid || step;

    tksd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tksd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_is_tick   (r_in_tick),
        .i_data_byte (r_in_byte),
        .i_cfg       (cfg),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.ready) begin
            r_in_valid <= i_in_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_tick <= i_in_ch.is_tick;
            r_in_byte <= i_in_ch.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= res.valid;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_out_ch.valid     = r_out_valid;
    assign o_out_ch.key_code  = r_out.key_code;
    assign o_out_ch.char_code = r_out.char_code;
    assign o_out_ch.ctrl_flag = r_out.ctrl_flag;
    assign o_out_ch.alt_flag  = r_out.alt_flag;

endmodule

`default_nettype wire
